@@ rtl/mppt_perturb_observe_averaged_macros.svh @@
// Assertion macros for the averaged perturb-and-observe tracker checker.
// Expects clk_i and rst_ni in the scope where they are used.
`ifndef MPPT_PERTURB_OBSERVE_AVERAGED_MACROS_SVH
`define MPPT_PERTURB_OBSERVE_AVERAGED_MACROS_SVH

// Clocked property, switched off while reset is held.
`define MPPT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mppt assertion failed");

// Signal holds while an item is stalled.
`define MPPT_ASSERT_HOLD(lbl, vld, rdy, sig) \
  `MPPT_ASSERT(lbl, (vld && !rdy) |=> $stable(sig))

`endif

@@ rtl/mppt_pkg.sv @@
// Shared types, widths and constants of the averaged P&O tracker.
// No dependencies.
`default_nettype none

package mppt_pkg;

  localparam int unsigned IN_W            = 12;
  localparam int unsigned AVG_W           = 12;
  localparam int unsigned PWR_W           = 2 * AVG_W;
  localparam int unsigned DUTY_W          = 8;
  localparam int unsigned STEP_W          = 5;
  localparam int unsigned APB_AW          = 4;
  localparam int unsigned APB_DW          = 32;

  localparam int unsigned FRAME_PAIRS     = 33;
  localparam int unsigned CNT_W           = $clog2(FRAME_PAIRS);
  localparam int unsigned MAX_DUTY        = 160;
  localparam int unsigned AVG_SHIFT       = 5;
  localparam int unsigned AVG_MAX         = 4095;
  localparam int unsigned SAMPLE_BITS_DEF = 12;

  localparam int unsigned QDEPTH          = 2;
  localparam int unsigned QPTR_W          = $clog2(QDEPTH);
  localparam int unsigned QCNT_W          = $clog2(QDEPTH + 1);

  localparam logic [AVG_W-1:0]  VOLT_MARGIN  = AVG_W'(5);

  // Reset values of the registers
  localparam logic [AVG_W-1:0]  VTHR_RST     = AVG_W'(2000);
  localparam logic [STEP_W-1:0] STEP_RST     = STEP_W'(5);
  localparam logic [DUTY_W-1:0] STARTUP_RST  = DUTY_W'(100);

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_VTHR    = 2'd0;
  localparam logic [1:0] REG_STEP    = 2'd1;
  localparam logic [1:0] REG_STARTUP = 2'd2;
  localparam logic [1:0] REG_ENABLE  = 2'd3;

  typedef struct packed {
    logic [AVG_W-1:0]  vthr;
    logic [STEP_W-1:0] step;
    logic [DUTY_W-1:0] startup;
    logic              enable;
  } cfg_t;

  typedef struct packed {
    logic [AVG_W-1:0] avg_v;
    logic [AVG_W-1:0] avg_i;
  } avg_t;

endpackage

`default_nettype wire

@@ rtl/mppt_if.sv @@
// Handshake channels of the tracker: sample pairs in, tracking results out.
// Depends on mppt_pkg.
`default_nettype none

interface mppt_sample_if import mppt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IN_W-1:0]   current_sample;
  logic [IN_W-1:0]   voltage_sample;

  modport source (output valid, current_sample, voltage_sample, input ready);
  modport sink   (input valid, current_sample, voltage_sample, output ready);
endinterface

interface mppt_result_if import mppt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] tracked_duty;
  logic [DUTY_W-1:0] drive_value;
  logic              increasing;
  logic              below_threshold;
  logic [AVG_W-1:0]  avg_voltage;
  logic [AVG_W-1:0]  avg_current;

  modport source (output valid, tracked_duty, drive_value, increasing, below_threshold,
                  avg_voltage, avg_current, input ready);
  modport sink   (input valid, tracked_duty, drive_value, increasing, below_threshold,
                  avg_voltage, avg_current, output ready);
endinterface

`default_nettype wire

@@ rtl/mppt_perturb_observe_averaged.sv @@
// Averaged perturb-and-observe maximum power point tracker. One current and
// voltage sample pair is taken per clock cycle. Each frame of 33 pairs drops
// its first pair, averages the other 32 and yields one tracking result
// (new duty, drive value, direction, threshold flag, both averages); all
// other pairs yield nothing. A frame's result passes in order through the
// queue, written at the edge that takes its last pair, the power multiply
// register and the decision and result register. A two-entry queue of frame
// averages sits between the accumulator and the tracking stage, so the
// sample input keeps flowing while a result waits; only a frame-closing
// pair can stall, and only while that queue is full. Registers are written
// over APB at byte address 4*i. Depends on mppt_pkg, mppt_if and the cfg,
// front, fifo and back modules.
`default_nettype none

module mppt_perturb_observe_averaged import mppt_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  mppt_sample_if.sink            smp_i,
  mppt_result_if.source          res_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  cfg_t cfg;
  avg_t push_data, pop_data;
  logic push, q_full, pop, q_valid;

  assign pready = 1'b1;

  mppt_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  mppt_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .smp_i    (smp_i),
    .q_full_i (q_full),
    .push_o   (push),
    .avg_o    (push_data)
  );

  mppt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (pop_data)
  );

  mppt_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .q_valid_i (q_valid),
    .q_data_i  (pop_data),
    .pop_o     (pop),
    .res_o     (res_o)
  );

endmodule

`default_nettype wire

@@ rtl/mppt_cfg.sv @@
// APB register file of the tracker: threshold, step, startup duty, enable.
// Depends on mppt_pkg.
`default_nettype none

module mppt_cfg import mppt_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel_i,
  input  wire logic              penable_i,
  input  wire logic              pwrite_i,
  input  wire logic [APB_AW-1:0] paddr_i,
  input  wire logic [APB_DW-1:0] pwdata_i,
  output logic      [APB_DW-1:0] prdata_o,
  output cfg_t                   cfg_o
);

  cfg_t       cfg_q;
  logic [1:0] idx;
  logic       wr;

  assign idx = paddr_i[3:2];
  assign wr  = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vthr    <= VTHR_RST;
      cfg_q.step    <= STEP_RST;
      cfg_q.startup <= STARTUP_RST;
      cfg_q.enable  <= 1'b1;
    end else if (wr) begin
      unique case (idx)
        REG_VTHR:    cfg_q.vthr    <= pwdata_i[AVG_W-1:0];
        REG_STEP:    cfg_q.step    <= pwdata_i[STEP_W-1:0];
        REG_STARTUP: cfg_q.startup <= pwdata_i[DUTY_W-1:0];
        REG_ENABLE:  cfg_q.enable  <= pwdata_i[0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_VTHR:    prdata_o = APB_DW'(cfg_q.vthr);
      REG_STEP:    prdata_o = APB_DW'(cfg_q.step);
      REG_STARTUP: prdata_o = APB_DW'(cfg_q.startup);
      REG_ENABLE:  prdata_o = APB_DW'(cfg_q.enable);
      default:     prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/mppt_front.sv @@
// Front end: takes sample pairs, drops the first of each 33-pair frame,
// sums the rest and pushes the frame averages. Depends on mppt_pkg, mppt_if.
`default_nettype none

module mppt_front import mppt_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mppt_sample_if.sink smp_i,
  input  wire logic   q_full_i,
  output logic        push_o,
  output avg_t        avg_o
);

  localparam int unsigned SMPL_W = (SAMPLE_BITS < IN_W) ? SAMPLE_BITS : IN_W;
  localparam int unsigned SUM_W  = SMPL_W + $clog2(FRAME_PAIRS - 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0] isum_q, isum_d, vsum_q, vsum_d;
  logic [SUM_W-1:0] isum_nx, vsum_nx, ish, vsh;
  logic             first, last, acc;

  assign first = (cnt_q == '0);
  assign last  = (cnt_q == CNT_W'(FRAME_PAIRS - 1));

  // the frame-closing pair waits only when the queue has no room
  assign smp_i.ready = !(last && q_full_i);
  assign acc         = smp_i.valid && smp_i.ready;

  assign isum_nx = isum_q + SUM_W'(smp_i.current_sample[SMPL_W-1:0]);
  assign vsum_nx = vsum_q + SUM_W'(smp_i.voltage_sample[SMPL_W-1:0]);

  always_comb begin
    cnt_d  = cnt_q;
    isum_d = isum_q;
    vsum_d = vsum_q;
    if (acc) begin
      if (last) begin
        cnt_d  = '0;
        isum_d = '0;
        vsum_d = '0;
      end else begin
        cnt_d = cnt_q + 1'b1;
        if (!first) begin
          isum_d = isum_nx;
          vsum_d = vsum_nx;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      isum_q <= '0;
      vsum_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      isum_q <= isum_d;
      vsum_q <= vsum_d;
    end
  end

  // averages saturate when a short shift leaves more than 12 bits
  assign ish = isum_nx >> AVG_SHIFT;
  assign vsh = vsum_nx >> AVG_SHIFT;

  assign avg_o.avg_i = (ish > SUM_W'(AVG_MAX)) ? AVG_W'(AVG_MAX) : ish[AVG_W-1:0];
  assign avg_o.avg_v = (vsh > SUM_W'(AVG_MAX)) ? AVG_W'(AVG_MAX) : vsh[AVG_W-1:0];
  assign push_o      = acc && last;

endmodule

`default_nettype wire

@@ rtl/mppt_fifo.sv @@
// Short queue of frame averages between front and back end.
// Depends on mppt_pkg.
`default_nettype none

module mppt_fifo import mppt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  avg_t      data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output avg_t      data_o
);

  avg_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/mppt_back.sv @@
// Back end: power multiply stage, then the P&O decision, duty update and
// result register. Depends on mppt_pkg, mppt_if.
`default_nettype none

module mppt_back import mppt_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  cfg_t          cfg_i,
  input  wire logic     q_valid_i,
  input  avg_t          q_data_i,
  output logic          pop_o,
  mppt_result_if.source res_o
);

  // multiply stage
  logic              s1_vld_q;
  avg_t              s1_avg_q;
  logic [PWR_W-1:0]  s1_pwr_q, prod;
  logic              adv;

  // tracking state
  logic [PWR_W-1:0]  last_pwr_q;
  logic [AVG_W-1:0]  last_v_q;
  logic              dir_q, dir_d;
  logic [DUTY_W-1:0] duty_q, duty_d;

  // result register
  logic              rvld_q;
  logic [DUTY_W-1:0] rduty_q, rdrive_q;
  logic              rinc_q, rbelow_q;
  avg_t              ravg_q;

  logic              below;
  logic [DUTY_W:0]   limit, dsum;

  assign adv   = s1_vld_q && (!rvld_q || res_o.ready);
  assign pop_o = q_valid_i && (!s1_vld_q || adv);
  assign prod  = q_data_i.avg_v * q_data_i.avg_i;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_avg_q <= q_data_i;
      s1_pwr_q <= prod;
    end
  end

  assign below = (s1_avg_q.avg_v < cfg_i.vthr);
  assign limit = (DUTY_W + 1)'(MAX_DUTY) + (DUTY_W + 1)'(cfg_i.step);

  always_comb begin
    dir_d  = dir_q;
    dsum   = '0;
    duty_d = cfg_i.startup;
    if (!below) begin
      if (s1_pwr_q < last_pwr_q) begin
        if (dir_q) begin
          // a previous voltage under the margin counts as a fall
          if (last_v_q < VOLT_MARGIN || s1_avg_q.avg_v < last_v_q - VOLT_MARGIN) begin
            dir_d = 1'b0;
          end
        end else begin
          dir_d = 1'b1;
        end
      end
      if (dir_d) begin
        dsum = {1'b0, duty_q} + (DUTY_W + 1)'(cfg_i.step);
      end else if (duty_q < DUTY_W'(cfg_i.step)) begin
        dsum = limit + 1'b1;   // underflow lands on startup below
      end else begin
        dsum = {1'b0, duty_q} - (DUTY_W + 1)'(cfg_i.step);
      end
      priority if (dsum > limit) begin
        // a startup duty sitting exactly on the limit is still clamped
        duty_d = ({1'b0, cfg_i.startup} == limit) ? DUTY_W'(MAX_DUTY) : cfg_i.startup;
      end else if (dsum == limit) begin
        duty_d = DUTY_W'(MAX_DUTY);
      end else begin
        duty_d = dsum[DUTY_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      rvld_q     <= 1'b0;
      last_pwr_q <= '0;
      last_v_q   <= '0;
      dir_q      <= 1'b1;
      duty_q     <= STARTUP_RST;
    end else begin
      if (pop_o) begin
        s1_vld_q <= 1'b1;
      end else if (adv) begin
        s1_vld_q <= 1'b0;
      end
      if (adv) begin
        rvld_q     <= 1'b1;
        last_pwr_q <= s1_pwr_q;
        last_v_q   <= s1_avg_q.avg_v;
        dir_q      <= dir_d;
        duty_q     <= duty_d;
      end else if (res_o.ready) begin
        rvld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rduty_q  <= duty_d;
      rdrive_q <= cfg_i.enable ? duty_d : '0;
      rinc_q   <= dir_d;
      rbelow_q <= below;
      ravg_q   <= s1_avg_q;
    end
  end

  assign res_o.valid           = rvld_q;
  assign res_o.tracked_duty    = rduty_q;
  assign res_o.drive_value     = rdrive_q;
  assign res_o.increasing      = rinc_q;
  assign res_o.below_threshold = rbelow_q;
  assign res_o.avg_voltage     = ravg_q.avg_v;
  assign res_o.avg_current     = ravg_q.avg_i;

endmodule

`default_nettype wire

@@ rtl/mppt_checker.sv @@
// Port-level checks of the tracker, bound to the top level.
// Depends on mppt_pkg and the assertion macro header.
`default_nettype none

`include "mppt_perturb_observe_averaged_macros.svh"

module mppt_checker import mppt_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              res_valid_i,
  input wire logic              res_ready_i,
  input wire logic [DUTY_W-1:0] duty_i,
  input wire logic [DUTY_W-1:0] drive_i,
  input wire logic              psel_i,
  input wire logic              penable_i,
  input wire logic              pwrite_i,
  input wire logic [APB_AW-1:0] paddr_i,
  input wire logic [APB_DW-1:0] pwdata_i,
  input wire logic [APB_DW-1:0] prdata_i
);

  logic             vthr_sel, vthr_wr;
  logic [AVG_W-1:0] vthr_rd, vthr_wd;

  assign vthr_sel = (paddr_i[3:2] == REG_VTHR);
  assign vthr_wr  = psel_i && penable_i && pwrite_i && vthr_sel;
  assign vthr_rd  = prdata_i[AVG_W-1:0];
  assign vthr_wd  = pwdata_i[AVG_W-1:0];

  // drive is either the tracked duty or forced off
  `MPPT_ASSERT(a_drive_duty, res_valid_i |-> (drive_i == duty_i || drive_i == '0))

  // a threshold write reads back in the following cycle
  `MPPT_ASSERT(a_vthr_readback, vthr_wr ##1 vthr_sel |-> (vthr_rd == $past(vthr_wd)))

  `MPPT_ASSERT(a_res_hold, (res_valid_i && !res_ready_i) |=> res_valid_i)

  `MPPT_ASSERT_HOLD(a_duty_hold, res_valid_i, res_ready_i, duty_i)

endmodule

bind mppt_perturb_observe_averaged mppt_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .duty_i      (res_o.tracked_duty),
  .drive_i     (res_o.drive_value),
  .psel_i      (psel),
  .penable_i   (penable),
  .pwrite_i    (pwrite),
  .paddr_i     (paddr),
  .pwdata_i    (pwdata),
  .prdata_i    (prdata)
);

`default_nettype wire
